FILE: src/two_stacks_shared_array_core_defines.svh
// Assertion macros for the two stacks shared array core.
`ifndef TWO_STACKS_SHARED_ARRAY_CORE_DEFINES_SVH
`define TWO_STACKS_SHARED_ARRAY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSSA_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define TSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define TSSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define TSSA_ASSERT(label, clk, rst, cond, msg)
`define TSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define TSSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/tssa_pkg.sv
// Types and constants shared by the two stacks shared array core.
package tssa_pkg;
   localparam int WORD_W = 32;
   localparam int MODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int CNT_W = 7;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [MODE_W-1:0] MODE_PUSH_ONE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_TWO = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_ONE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_TWO = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SHOW_ONE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SHOW_TWO = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_PUSH_ONE,
      OP_PUSH_TWO,
      OP_POP_ONE,
      OP_POP_TWO,
      OP_SHOW_ONE,
      OP_SHOW_TWO
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SHOW
   } back_state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0] status;
      logic last;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic signed [WORD_W-1:0] push_value;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_one;
      logic [CNT_W-1:0] count_two;
      logic [CNT_W-1:0] stack_size;
   } back_status_type;
endpackage

FILE: src/tssa_front.sv
// Front end: accepts request words, decodes the mode and drops unknown modes.
module tssa_front (
   input  logic             req_valid,
   input  tssa_pkg::req_type req_data,
   output logic             req_stall,
   input  logic             q_full,
   output logic             q_push,
   output tssa_pkg::cmd_type q_data
);
   import tssa_pkg::*;

   logic known;

   always_comb begin
      known = 1'b1;
      q_data.push_value = req_data.push_value;
      q_data.op = OP_PUSH_ONE;
      case (req_data.mode)
         MODE_PUSH_ONE: q_data.op = OP_PUSH_ONE;
         MODE_PUSH_TWO: q_data.op = OP_PUSH_TWO;
         MODE_POP_ONE: q_data.op = OP_POP_ONE;
         MODE_POP_TWO: q_data.op = OP_POP_TWO;
         MODE_SHOW_ONE: q_data.op = OP_SHOW_ONE;
         MODE_SHOW_TWO: q_data.op = OP_SHOW_TWO;
         default: known = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full && known;
endmodule

FILE: src/tssa_queue.sv
// Short command queue between the front end and the back end.
module tssa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tssa_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output tssa_pkg::cmd_type pop_data
);
   import tssa_pkg::*;

   cmd_type entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0] fill_ff, fill_in;
   logic do_pop;

   assign full = (fill_ff == (QPTR_W+1)'(QDEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data = entry_ff[rptr_ff];
   assign do_pop = pop && pop_valid;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end
endmodule

FILE: src/tssa_back.sv
// Back end: stack counters, shared word memory and the result register.
module tssa_back #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  tssa_pkg::cmd_type         q_data,
   output logic                     q_pop,
   input  logic                     csr_wr_en,
   input  logic [tssa_pkg::CNT_W-1:0] csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tssa_pkg::rsp_type         rsp_data,
   output tssa_pkg::back_status_type status
);
   import tssa_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_one_ff, count_one_in;
   logic [CNT_W-1:0] count_two_ff, count_two_in;
   logic [CNT_W-1:0] stack_size_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic dir_ff, dir_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [CNT_W-1:0] top_one, top_two, below_two, last_two;
   logic [CNT_W:0] used;
   logic full, out_free, show_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign used = {1'b0, count_one_ff} + {1'b0, count_two_ff};
   assign full = used >= {1'b0, stack_size_ff};
   assign top_one = count_one_ff - ONE_C;
   assign top_two = stack_size_ff - count_two_ff;
   assign below_two = top_two - ONE_C;
   assign last_two = stack_size_ff - ONE_C;
   assign show_last = dir_ff ? (idx_ff == last_two[AW-1:0]) : (idx_ff == '0);

   always_comb begin
      state_in = state_ff;
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      idx_in = idx_ff;
      dir_in = dir_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      mem_we = 1'b0;
      mem_waddr = count_one_ff[AW-1:0];
      mem_re = 1'b0;
      mem_raddr = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               rsp_in.value = '0;
               rsp_in.status = ST_OK;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               case (q_data.op)
                  OP_PUSH_ONE: begin
                     if (full) begin
                        rsp_in.status = ST_OVERFLOW;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = count_one_ff[AW-1:0];
                        count_one_in = count_one_ff + ONE_C;
                     end
                  end
                  OP_PUSH_TWO: begin
                     if (full) begin
                        rsp_in.status = ST_OVERFLOW;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = below_two[AW-1:0];
                        count_two_in = count_two_ff + ONE_C;
                     end
                  end
                  OP_POP_ONE: begin
                     if (count_one_ff == '0) begin
                        rsp_in.value = WORD_MIN;
                        rsp_in.status = ST_UNDERFLOW;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_re = 1'b1;
                        mem_raddr = top_one[AW-1:0];
                        count_one_in = top_one;
                        state_in = BK_READ;
                     end
                  end
                  OP_POP_TWO: begin
                     if (count_two_ff == '0) begin
                        rsp_in.value = WORD_MIN;
                        rsp_in.status = ST_UNDERFLOW;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_re = 1'b1;
                        mem_raddr = top_two[AW-1:0];
                        count_two_in = count_two_ff - ONE_C;
                        state_in = BK_READ;
                     end
                  end
                  OP_SHOW_ONE: begin
                     if (count_one_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_re = 1'b1;
                        mem_raddr = top_one[AW-1:0];
                        idx_in = top_one[AW-1:0];
                        dir_in = 1'b0;
                        state_in = BK_SHOW;
                     end
                  end
                  OP_SHOW_TWO: begin
                     if (count_two_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_re = 1'b1;
                        mem_raddr = top_two[AW-1:0];
                        idx_in = top_two[AW-1:0];
                        dir_in = 1'b1;
                        state_in = BK_SHOW;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.value = rd_data_ff;
               rsp_in.status = ST_OK;
               rsp_in.last = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_SHOW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.value = rd_data_ff;
               rsp_in.status = ST_OK;
               rsp_in.last = show_last;
               if (show_last) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in = dir_ff ? idx_ff + 1'b1 : idx_ff - 1'b1;
                  mem_re = 1'b1;
                  mem_raddr = idx_in;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_one_ff <= '0;
         count_two_ff <= '0;
         stack_size_ff <= DEPTH_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_one_ff <= '0;
            count_two_ff <= '0;
            if (csr_wr_data == '0) begin
               stack_size_ff <= ONE_C;
            end else if (csr_wr_data > DEPTH_C) begin
               stack_size_ff <= DEPTH_C;
            end else begin
               stack_size_ff <= csr_wr_data;
            end
         end else begin
            count_one_ff <= count_one_in;
            count_two_ff <= count_two_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dir_ff <= dir_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= q_data.push_value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign status.count_one = count_one_ff;
   assign status.count_two = count_two_ff;
   assign status.stack_size = stack_size_ff;
endmodule

FILE: src/two_stacks_shared_array_core.sv
// Two stacks in one shared word memory, front end, command queue and back end.
// Push, underflow and empty show answers go to the result register when the word
// is taken; pop and non-empty show first go through the registered memory read.
// Throughput: push one word a cycle while the output is not stalled; pop and show
// hold the back end until their last word is sent, set by the single read port.
// Reset: synchronous; both stacks empty, stack_size = DEPTH, memory not cleared.
`include "two_stacks_shared_array_core_defines.svh"
module two_stacks_shared_array_core #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tssa_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tssa_pkg::rsp_type         rsp_data,
   input  logic                     csr_wr_en,
   input  logic [tssa_pkg::CNT_W-1:0] csr_wr_data
);
   import tssa_pkg::*;

   logic q_full, q_push, q_pop, q_valid;
   cmd_type q_in, q_out;
   back_status_type status;

   tssa_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   tssa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   tssa_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_out),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .status      (status)
   );

   `TSSA_ASSERT(a_fill_bound, clock, reset, ({1'b0, status.count_one} + {1'b0, status.count_two}) <= {1'b0, status.stack_size}, "Stacks hold more words than the size")
   `TSSA_ASSERT(a_size_range, clock, reset, (status.stack_size != '0) && (status.stack_size <= CNT_W'(DEPTH)), "Stack size out of range")
   `TSSA_ASSERT_NEXT(a_csr_clear, clock, reset, csr_wr_en, (status.count_one == '0) && (status.count_two == '0), "Size write did not empty the stacks")
   `TSSA_ASSERT_IMPL(a_overflow_zero, clock, reset, rsp_valid && (rsp_data.status == ST_OVERFLOW), (rsp_data.value == '0) && rsp_data.last, "Overflow word is malformed")
endmodule

FILE: test/testbench.sv
// Testbench for the two stacks shared array core: directed and random traffic against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tssa_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int QUIET_CYCLES = 6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   typedef enum {ACT_ITEM, ACT_SIZE, ACT_DRAIN} action_kind_type;
   typedef enum {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_style_type;

   typedef struct {
      action_kind_type kind;
      req_type    req;
      logic [CNT_W-1:0] size;
   } stack_action_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   stack_action_type pending[$];
   rsp_type     expected_rsps[$];
   int          mismatches = 0;
   bit          req_accepted = 1'b0;

   logic signed [WORD_W-1:0] shared_words[STORE_DEPTH];
   logic [CNT_W-1:0] count_one;
   logic [CNT_W-1:0] count_two;
   logic [CNT_W-1:0] active_size;

   int quiet_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   stall_style_type stall_style = STALL_NONE;
   int style_left = 0;
   int stall_run = 0;

   two_stacks_shared_array_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic add_item(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
      stack_action_type a;
      a.kind = ACT_ITEM;
      a.req.mode = mode;
      a.req.push_value = value;
      a.size = '0;
      pending.push_back(a);
   endtask

   task automatic add_size(input logic [CNT_W-1:0] size);
      stack_action_type a;
      a.kind = ACT_SIZE;
      a.req = '0;
      a.size = size;
      pending.push_back(a);
   endtask

   task automatic add_drain();
      stack_action_type a;
      a.kind = ACT_DRAIN;
      a.req = '0;
      a.size = '0;
      pending.push_back(a);
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return MODE_PUSH_ONE;
      if (r < 55) return MODE_PUSH_TWO;
      if (r < 70) return MODE_POP_ONE;
      if (r < 85) return MODE_POP_TWO;
      if (r < 92) return MODE_SHOW_ONE;
      if (r < 98) return MODE_SHOW_TWO;
      return (r == 98) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
   endfunction

   task automatic note_rsp(input logic [WORD_W-1:0] value, input logic [STATUS_W-1:0] status,
                           input logic last);
      rsp_type x;
      x.value = value;
      x.status = status;
      x.last = last;
      expected_rsps.push_back(x);
   endtask

   task automatic predict_stacks(input req_type r);
      bit full;
      int i;
      int low;
      full = (int'(count_one) + int'(count_two)) >= int'(active_size);
      low = int'(active_size) - int'(count_two);
      case (r.mode)
         MODE_PUSH_ONE: begin
            if (full) begin
               note_rsp('0, ST_OVERFLOW, 1'b1);
            end else begin
               shared_words[count_one] = r.push_value;
               count_one = count_one + 1'b1;
               note_rsp('0, ST_OK, 1'b1);
            end
         end
         MODE_PUSH_TWO: begin
            if (full) begin
               note_rsp('0, ST_OVERFLOW, 1'b1);
            end else begin
               count_two = count_two + 1'b1;
               shared_words[active_size - count_two] = r.push_value;
               note_rsp('0, ST_OK, 1'b1);
            end
         end
         MODE_POP_ONE: begin
            if (count_one == 0) begin
               note_rsp(WORD_MIN, ST_UNDERFLOW, 1'b1);
            end else begin
               count_one = count_one - 1'b1;
               note_rsp(shared_words[count_one], ST_OK, 1'b1);
            end
         end
         MODE_POP_TWO: begin
            if (count_two == 0) begin
               note_rsp(WORD_MIN, ST_UNDERFLOW, 1'b1);
            end else begin
               note_rsp(shared_words[low], ST_OK, 1'b1);
               count_two = count_two - 1'b1;
            end
         end
         MODE_SHOW_ONE: begin
            if (count_one == 0) begin
               note_rsp('0, ST_EMPTY, 1'b1);
            end else begin
               for (i = int'(count_one); i > 0; i--) begin
                  note_rsp(shared_words[i-1], ST_OK, i == 1);
               end
            end
         end
         MODE_SHOW_TWO: begin
            if (count_two == 0) begin
               note_rsp('0, ST_EMPTY, 1'b1);
            end else begin
               for (i = low; i < int'(active_size); i++) begin
                  note_rsp(shared_words[i], ST_OK, i + 1 == int'(active_size));
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // Result check first, then prediction, so a word predicted at this edge is never matched here.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_accepted = 1'b0;
         count_one = '0;
         count_two = '0;
         active_size = CNT_W'(STORE_DEPTH);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word value=%0d status=%0d last=%0b", $time,
                        rsp_data.value, rsp_data.status, rsp_data.last);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.value !== want.value || rsp_data.status !== want.status ||
                   rsp_data.last !== want.last) begin
                  mismatches++;
                  $display("%0t: expected value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
                           $time, want.value, want.status, want.last,
                           rsp_data.value, rsp_data.status, rsp_data.last);
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_wr_data == 0) active_size = CNT_W'(1);
            else if (int'(csr_wr_data) > STORE_DEPTH) active_size = CNT_W'(STORE_DEPTH);
            else active_size = csr_wr_data;
            count_one = '0;
            count_two = '0;
         end
         req_accepted = req_valid && !req_stall;
         if (req_accepted) predict_stacks(req_data);
      end
   end

   always @(negedge clock) begin
      stack_action_type act;
      logic nv;
      req_type nd;
      logic nwe;
      logic [CNT_W-1:0] nwd;
      nv = req_valid;
      nd = req_data;
      nwe = 1'b0;
      nwd = csr_wr_data;
      if (reset) begin
         nv = 1'b0;
         quiet_count = 0;
      end else begin
         if (req_valid && req_accepted) nv = 1'b0;
         if (nv || expected_rsps.size() != 0) quiet_count = 0;
         else quiet_count++;
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0) begin
               act = pending[0];
               if (act.kind == ACT_ITEM) begin
                  nv = 1'b1;
                  nd = act.req;
                  void'(pending.pop_front());
                  burst_left--;
                  if (burst_left <= 0) begin
                     burst_left = $urandom_range(1, 20);
                     gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                  end
               end else if (quiet_count >= QUIET_CYCLES) begin
                  if (act.kind == ACT_SIZE) begin
                     nwe = 1'b1;
                     nwd = act.size;
                  end
                  void'(pending.pop_front());
                  quiet_count = 0;
               end
            end
         end
      end
      req_valid <= nv;
      req_data <= nd;
      csr_wr_en <= nwe;
      csr_wr_data <= nwd;
   end

   always @(negedge clock) begin
      logic ns;
      ns = 1'b0;
      if (!reset) begin
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(20, 80);
         end
         style_left--;
         case (stall_style)
            STALL_NONE: ns = 1'b0;
            STALL_SPARSE: ns = ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_run > 0) begin
                  stall_run--;
                  ns = 1'b1;
               end else if ($urandom_range(0, 7) == 0) begin
                  stall_run = $urandom_range(1, 6);
               end
            end
         endcase
      end
      rsp_stall <= ns;
   end

   initial begin
      int phase;
      int n;
      int k;
      logic [CNT_W-1:0] sz;

      // Empty stacks, ignored modes, extreme words, then the one-entry store.
      add_item(MODE_POP_ONE, 32'h1234_5678);
      add_item(MODE_POP_TWO, 32'h0);
      add_item(MODE_SHOW_ONE, 32'h0);
      add_item(MODE_SHOW_TWO, 32'hFFFF_FFFF);
      add_item(MODE_UNUSED_LO, 32'hDEAD_BEEF);
      add_item(MODE_UNUSED_HI, 32'h0BAD_F00D);
      add_item(MODE_PUSH_ONE, 32'h7FFF_FFFF);
      add_item(MODE_PUSH_ONE, 32'h8000_0000);
      add_item(MODE_PUSH_TWO, 32'h0000_0000);
      add_item(MODE_PUSH_TWO, 32'hFFFF_FFFF);
      add_item(MODE_PUSH_ONE, 32'h5555_5555);
      add_item(MODE_PUSH_TWO, 32'hAAAA_AAAA);
      add_item(MODE_SHOW_ONE, 32'h0);
      add_item(MODE_SHOW_TWO, 32'h0);
      add_item(MODE_POP_ONE, 32'h0);
      add_item(MODE_POP_TWO, 32'h0);
      add_size(7'd1);
      add_item(MODE_PUSH_ONE, 32'hCAFE_0001);
      add_item(MODE_PUSH_TWO, 32'hCAFE_0002);
      add_item(MODE_POP_TWO, 32'h0);
      add_item(MODE_POP_ONE, 32'h0);
      add_size(7'd0);
      add_item(MODE_PUSH_TWO, 32'hCAFE_0003);
      add_item(MODE_PUSH_ONE, 32'hCAFE_0004);
      add_item(MODE_SHOW_TWO, 32'h0);
      add_item(MODE_POP_TWO, 32'h0);

      for (phase = 0; phase < 7; phase++) begin
         if (phase == 2) sz = 7'd127;
         else if (phase == 5) sz = CNT_W'($urandom_range(65, 127));
         else sz = CNT_W'($urandom_range(0, 8));
         add_size(sz);
         n = $urandom_range(3, 5);
         for (k = 0; k < n; k++) begin
            if (phase == 3 && k == n / 2) add_drain();
            add_item(pick_mode(), rand_word());
         end
      end

      // Both stacks meet in the full store, then long shows.
      add_size(7'd64);
      for (k = 0; k < STORE_DEPTH; k++) begin
         add_item(($urandom_range(0, 3) == 0) ? MODE_PUSH_TWO : MODE_PUSH_ONE, rand_word());
      end
      add_item(MODE_PUSH_ONE, rand_word());
      add_item(MODE_PUSH_TWO, rand_word());
      add_item(MODE_SHOW_ONE, rand_word());
      add_item(MODE_SHOW_TWO, rand_word());
      add_item(MODE_POP_ONE, rand_word());
      add_item(MODE_POP_TWO, rand_word());

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending.size() != 0 || req_valid || expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
